// File: rtl/opt_pkg.sv
// ----------------------------------------------------------------------------
// opt_pkg
// Shared types and constants for the ordered point table.
// ----------------------------------------------------------------------------
package opt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 6;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int VAL_W    = 16;

	localparam logic [2:0] CMD_APPEND   = 3'd0;
	localparam logic [2:0] CMD_DEL_POS  = 3'd1;
	localparam logic [2:0] CMD_DEL_ID   = 3'd2;
	localparam logic [2:0] CMD_READ_POS = 3'd3;
	localparam logic [2:0] CMD_READ_ID  = 3'd4;

	typedef struct packed {
		logic [VAL_W-1:0] id;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
	} entry_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             wr_en;
		logic             shift_en;
		logic [VAL_W-1:0] key;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
		entry_t           wr_data;
	} ctl_t;

endpackage

// File: rtl/ordered_point_table.sv
// ----------------------------------------------------------------------------
// ordered_point_table
// Ordered point table with append, compacting delete and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: drive cmd/position/point_id/x_coord/y_coord with start high;
//   the beat is taken on a rising edge where busy is low. busy stays high
//   while the command is worked on.
//   Result beat: done pulses for one cycle with ok, where, found_*, and
//   entry_count. The receiver cannot stall; the beat must be taken then.
//   Exactly one result per command.
// Steps after accept (done is set as the last one ends):
//   append / unknown code : reply
//   by position           : read, reply
//   by id                 : match, first-match encode, read, reply
//   A new command can be taken in the same cycle done is shown.
//   The steps are set by the cell row: all keys are compared, the first hit
//   is encoded, the selected slot is gated onto the read bus, each registered;
//   a delete shifts every later slot down in the reply cycle.
// Reset: arst_n clears the sequencer, count and result registers; slot contents
//   are left as is, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_point_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [opt_pkg::POS_W-1:0]  position,
	input  logic [opt_pkg::VAL_W-1:0]  point_id,
	input  logic [opt_pkg::VAL_W-1:0]  x_coord,
	input  logic [opt_pkg::VAL_W-1:0]  y_coord,
	output logic                       done,
	output logic                       ok,
	output logic [opt_pkg::POS_W-1:0]  where,
	output logic [opt_pkg::VAL_W-1:0]  found_id,
	output logic [opt_pkg::VAL_W-1:0]  found_x,
	output logic [opt_pkg::VAL_W-1:0]  found_y,
	output logic [opt_pkg::CNT_W-1:0]  entry_count
);
	import opt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REPLY,
		ST_MATCH,
		ST_ENCODE,
		ST_READ,
		ST_FETCH
	} state_t;

	state_t           state_q;
	logic [2:0]       cmd_q;
	logic [POS_W-1:0] at_q;
	logic             hit_q;
	logic [CNT_W-1:0] count_q;
	entry_t           new_q;

	logic             done_q;
	logic             ok_q;
	logic [POS_W-1:0] where_q;
	entry_t           res_q;

	ctl_t             ctl;
	logic             enc_hit;
	logic [IDX_W-1:0] enc_idx;
	entry_t           rd_data;
	logic             accept;
	logic             is_del;
	logic             room;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign is_del = (cmd_q == CMD_DEL_POS) || (cmd_q == CMD_DEL_ID);
	assign room   = (CMP_W'(count_q) < CMP_W'(CAPACITY));

	// broadcast to the cell row
	always_comb begin
		ctl          = '0;
		ctl.key      = new_q.id;
		ctl.pos      = at_q;
		ctl.count    = count_q;
		ctl.wr_data  = new_q;
		ctl.wr_en    = (state_q == ST_REPLY) && (cmd_q == CMD_APPEND) && room;
		ctl.shift_en = (state_q == ST_FETCH) && is_del && hit_q;
	end

	opt_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.hit     (enc_hit),
		.hit_idx (enc_idx),
		.rd_data (rd_data)
	);

	// command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			new_q.id  <= point_id;
			new_q.x   <= x_coord;
			new_q.y   <= y_coord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			where_q <= '0;
			res_q   <= '0;
			at_q    <= '0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						at_q  <= position;
						hit_q <= CMP_W'(position) < CMP_W'(count_q);
						if (cmd == CMD_DEL_POS || cmd == CMD_READ_POS) begin
							state_q <= ST_READ;
						end else if (cmd == CMD_DEL_ID || cmd == CMD_READ_ID) begin
							state_q <= ST_MATCH;
						end else begin
							state_q <= ST_REPLY;
						end
					end
				end
				ST_REPLY: begin
					// append, or an unknown code that always fails
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
					if (cmd_q == CMD_APPEND && room) begin
						ok_q    <= 1'b1;
						where_q <= POS_W'(count_q);
						res_q   <= new_q;
						count_q <= count_q + CNT_W'(1);
					end else begin
						ok_q    <= 1'b0;
						where_q <= '0;
						res_q   <= '0;
					end
				end
				ST_MATCH: begin
					state_q <= ST_ENCODE;
				end
				ST_ENCODE: begin
					at_q    <= POS_W'(enc_idx);
					hit_q   <= enc_hit;
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					done_q  <= 1'b1;
					ok_q    <= hit_q;
					where_q <= hit_q ? at_q : '0;
					res_q   <= hit_q ? rd_data : '0;
					if (is_del && hit_q) begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign where       = where_q;
	assign found_id    = res_q.id;
	assign found_x     = res_q.x;
	assign found_y     = res_q.y;
	assign entry_count = count_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("entry count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !ok_q) |-> (where_q == '0 && res_q == '0))
		else $error("failed result carries data");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy && $past(busy)))
		else $error("result beat not at end of a command");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> $stable(count_q))
		else $error("count changed without a result");

endmodule

// File: rtl/opt_cell.sv
// ----------------------------------------------------------------------------
// opt_cell
// One table slot: holds a point, flags a key match, drives the read bus.
// ----------------------------------------------------------------------------
module opt_cell (
	input  logic                 clk,
	input  opt_pkg::ctl_t        ctl,
	input  logic [opt_pkg::IDX_W-1:0] cell_idx,
	input  opt_pkg::entry_t      nxt,
	output opt_pkg::entry_t      entry,
	output logic                 match,
	output opt_pkg::entry_t      rd
);
	import opt_pkg::*;

	entry_t entry_q;
	entry_t rd_q;
	logic   match_q;
	logic [CMP_W-1:0] my_idx;

	assign my_idx = CMP_W'(cell_idx);

	always_ff @(posedge clk) begin
		if (ctl.wr_en && my_idx == CMP_W'(ctl.count)) begin
			entry_q <= ctl.wr_data;
		end else if (ctl.shift_en && my_idx >= CMP_W'(ctl.pos)) begin
			entry_q <= nxt;
		end
		// only occupied slots may match
		match_q <= (entry_q.id == ctl.key) && (my_idx < CMP_W'(ctl.count));
		rd_q    <= (my_idx == CMP_W'(ctl.pos)) ? entry_q : '0;
	end

	assign entry = entry_q;
	assign match = match_q;
	assign rd    = rd_q;

endmodule

// File: rtl/opt_chain.sv
// ----------------------------------------------------------------------------
// opt_chain
// Row of table cells with first-match encoder and OR read bus.
// ----------------------------------------------------------------------------
module opt_chain (
	input  logic                       clk,
	input  opt_pkg::ctl_t              ctl,
	output logic                       hit,
	output logic [opt_pkg::IDX_W-1:0]  hit_idx,
	output opt_pkg::entry_t            rd_data
);
	import opt_pkg::*;

	entry_t             ent   [CAPACITY];
	entry_t             rdv   [CAPACITY];
	logic [CAPACITY-1:0] mvec;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		entry_t nxt_g;
		if (g == CAPACITY - 1) begin : g_last
			assign nxt_g = ent[g];
		end else begin : g_mid
			assign nxt_g = ent[g+1];
		end
		opt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.cell_idx (IDX_W'(g)),
			.nxt      (nxt_g),
			.entry    (ent[g]),
			.match    (mvec[g]),
			.rd       (rdv[g])
		);
	end

	// lowest matching slot wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (mvec[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	// at most one cell drives a nonzero value
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | rdv[i];
		end
	end

endmodule

// File: sim/point_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_table_checker
// Watches the command and result beats of the ordered point table, keeps a
// shadow copy of the table, and compares every result field with it.
// ----------------------------------------------------------------------------
module point_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [opt_pkg::POS_W-1:0]  position,
	input  logic [opt_pkg::VAL_W-1:0]  point_id,
	input  logic [opt_pkg::VAL_W-1:0]  x_coord,
	input  logic [opt_pkg::VAL_W-1:0]  y_coord,
	input  logic                       done,
	input  logic                       ok,
	input  logic [opt_pkg::POS_W-1:0]  where,
	input  logic [opt_pkg::VAL_W-1:0]  found_id,
	input  logic [opt_pkg::VAL_W-1:0]  found_x,
	input  logic [opt_pkg::VAL_W-1:0]  found_y,
	input  logic [opt_pkg::CNT_W-1:0]  entry_count,
	output int                         mismatches,
	output int                         waiting,
	output int                         fill,
	output int                         checked,
	output int                         refusals
);
	import opt_pkg::*;

	typedef struct packed {
		logic             ok;
		logic [POS_W-1:0] where;
		logic [VAL_W-1:0] id;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [CNT_W-1:0] count;
	} reply_t;

	entry_t table_pts [CAPACITY];
	int     table_held;
	reply_t pending_replies [$];

	// apply one command to the shadow table, return the reply it should give
	function automatic reply_t apply_command(input logic [2:0] op,
		input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] key,
		input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py);
		reply_t r;
		logic   hit;
		int     slot;
		r    = '0;
		hit  = 1'b0;
		slot = 0;
		case (op)
			CMD_APPEND: begin
				if (table_held < CAPACITY) begin
					table_pts[table_held] = {key, px, py};
					hit  = 1'b1;
					slot = table_held;
					table_held++;
				end
			end
			CMD_DEL_POS, CMD_READ_POS: begin
				if (pos < table_held) begin
					hit  = 1'b1;
					slot = pos;
				end
			end
			CMD_DEL_ID, CMD_READ_ID: begin
				// walk down so the lowest match wins
				for (int i = table_held - 1; i >= 0; i--) begin
					if (table_pts[i].id == key) begin
						hit  = 1'b1;
						slot = i;
					end
				end
			end
			default: ;
		endcase
		if (hit) begin
			r.ok    = 1'b1;
			r.where = slot[POS_W-1:0];
			r.id    = table_pts[slot].id;
			r.x     = table_pts[slot].x;
			r.y     = table_pts[slot].y;
			if (op == CMD_DEL_POS || op == CMD_DEL_ID) begin
				for (int i = slot; i < table_held - 1; i++)
					table_pts[i] = table_pts[i + 1];
				table_held--;
			end
		end
		r.count = table_held[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
		input logic [VAL_W-1:0] want);
		$display("[%0t] result mismatch on %s: got %0h, expected %0h",
			$time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			table_held = 0;
			pending_replies.delete();
			mismatches = 0;
			checked    = 0;
			refusals   = 0;
			waiting   <= 0;
			fill      <= 0;
		end else begin
			// result first: it always belongs to an older command
			if (done) begin
				if (pending_replies.size() == 0) begin
					report_mismatch("unexpected beat", '0, '0);
				end else begin
					want = pending_replies.pop_front();
					if (ok !== want.ok)
						report_mismatch("ok", ok, want.ok);
					if (where !== want.where)
						report_mismatch("where", where, want.where);
					if (found_id !== want.id)
						report_mismatch("found_id", found_id, want.id);
					if (found_x !== want.x)
						report_mismatch("found_x", found_x, want.x);
					if (found_y !== want.y)
						report_mismatch("found_y", found_y, want.y);
					if (entry_count !== want.count)
						report_mismatch("entry_count", entry_count, want.count);
					checked++;
				end
			end
			if (start && !busy) begin
				want = apply_command(cmd, position, point_id, x_coord, y_coord);
				if (cmd == CMD_APPEND && !want.ok)
					refusals++;
				pending_replies.push_back(want);
			end
			waiting <= pending_replies.size();
			fill    <= table_held;
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into the ordered point table: a directed pass over
// empty-table failures, unknown codes, extreme values, duplicate ids and
// out-of-range positions, then random fill/drain traffic under several
// sender idle rates. Results are checked beat by beat by the checker.
// ----------------------------------------------------------------------------
module testbench;
	import opt_pkg::*;

	localparam int BEATS_PER_PHASE = 256;
	localparam int QUIET_LIMIT     = 1000;  // by-id ops are the slowest; idle runs are short
	localparam int TAIL_CYCLES     = 10;    // longer than the slowest latency

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         cmd;
	logic [POS_W-1:0]   position;
	logic [VAL_W-1:0]   point_id;
	logic [VAL_W-1:0]   x_coord;
	logic [VAL_W-1:0]   y_coord;
	logic               done;
	logic               ok;
	logic [POS_W-1:0]   where;
	logic [VAL_W-1:0]   found_id;
	logic [VAL_W-1:0]   found_x;
	logic [VAL_W-1:0]   found_y;
	logic [CNT_W-1:0]   entry_count;

	int mismatches;
	int waiting;
	int fill;
	int checked;
	int refusals;
	int issued       = 0;
	int quiet_cycles = 0;

	ordered_point_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.point_id    (point_id),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.done        (done),
		.ok          (ok),
		.where       (where),
		.found_id    (found_id),
		.found_x     (found_x),
		.found_y     (found_y),
		.entry_count (entry_count)
	);

	point_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.point_id    (point_id),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.done        (done),
		.ok          (ok),
		.where       (where),
		.found_id    (found_id),
		.found_x     (found_x),
		.found_y     (found_y),
		.entry_count (entry_count),
		.mismatches  (mismatches),
		.waiting     (waiting),
		.fill        (fill),
		.checked     (checked),
		.refusals    (refusals)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: any accepted command or result beat resets the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, waiting);
			$display("FAIL ordered_point_table");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one command beat and hold it until the table takes it.
	// start is left high so a back-to-back beat can be taken without it dropping.
	task automatic send_beat(input logic [2:0] op, input int pos,
		input logic [VAL_W-1:0] key, input logic [VAL_W-1:0] px,
		input logic [VAL_W-1:0] py);
		start    <= 1'b1;
		cmd      <= op;
		position <= pos[POS_W-1:0];
		point_id <= key;
		x_coord  <= px;
		y_coord  <= py;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		issued++;
	endtask

	// Each cycle idles with the given percent chance, so gaps land anywhere.
	task automatic idle_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		logic [VAL_W-1:0] id_pool [16];
		logic             filling;
		logic [2:0]       op;
		logic [VAL_W-1:0] key;
		int               pos;
		int               pct;
		int               roll;

		arst_n   <= 1'b0;
		start    <= 1'b0;
		cmd      <= CMD_APPEND;
		position <= '0;
		point_id <= '0;
		x_coord  <= '0;
		y_coord  <= '0;
		// small id pool so searches hit and duplicates occur
		for (int i = 0; i < 16; i++)
			id_pool[i] = VAL_W'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// everything fails on an empty table
		send_beat(CMD_READ_POS, 0, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_READ_ID,  0, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_DEL_POS,  0, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_DEL_ID,   0, 16'h0000, 16'h0000, 16'h0000);
		// unknown codes fail and change nothing
		for (int c = CMD_READ_ID + 1; c < 8; c++)
			send_beat(c[2:0], 63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// extreme values, then a duplicated id
		send_beat(CMD_APPEND, 0, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_APPEND, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(CMD_APPEND, 0, 16'h1234, 16'hAAAA, 16'h5555);
		send_beat(CMD_APPEND, 0, 16'h1234, 16'h5555, 16'hAAAA);
		send_beat(CMD_READ_ID,  0, 16'h1234, 16'h0000, 16'h0000);  // lowest match, pos 2
		send_beat(CMD_READ_POS, 3, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_READ_POS, 4, 16'h0000, 16'h0000, 16'h0000);  // at count
		send_beat(CMD_READ_POS, 63, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_READ_ID,  0, 16'hFFFF, 16'h0000, 16'h0000);
		send_beat(CMD_READ_ID,  0, 16'hBEEF, 16'h0000, 16'h0000);  // absent
		send_beat(CMD_DEL_ID,   0, 16'h1234, 16'h0000, 16'h0000);  // first copy goes
		send_beat(CMD_READ_POS, 2, 16'h0000, 16'h0000, 16'h0000);  // second slid down
		send_beat(CMD_DEL_POS,  0, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_DEL_ID,   0, 16'h4321, 16'h0000, 16'h0000);  // absent
		send_beat(CMD_DEL_POS,  63, 16'h0000, 16'h0000, 16'h0000);
		send_beat(CMD_DEL_POS,  2, 16'h0000, 16'h0000, 16'h0000);  // at count
		send_beat(CMD_DEL_POS,  1, 16'h0000, 16'h0000, 16'h0000);  // tail entry
		send_beat(CMD_DEL_POS,  0, 16'h0000, 16'h0000, 16'h0000);  // back to empty

		// --- random ---
		// Fill until full (with a few refused appends), then drain to empty,
		// over and over. fill is the checker's count as of the last edge.
		// Phases: no gaps, sender idle 51%, no gaps (receiver never stalls), 34%.
		filling = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			pct = (ph == 1) ? 51 : (ph == 3) ? 34 : 0;
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				if (fill == 0)
					filling = 1'b1;
				else if (fill >= CAPACITY && $urandom_range(3) == 0)
					filling = 1'b0;

				roll = $urandom_range(99);
				if (roll < 3)
					op = 3'($urandom_range(7, CMD_READ_ID + 1));
				else if (roll < (filling ? 60 : 20))
					op = CMD_APPEND;
				else
					op = 3'($urandom_range(CMD_READ_ID, CMD_DEL_POS));

				// mostly positions near the live range, count itself included
				if ($urandom_range(9) < 8)
					pos = $urandom_range(fill, 0);
				else
					pos = $urandom_range(63);
				if (pos > 63)
					pos = 63;

				key = ($urandom_range(9) < 8) ? id_pool[$urandom_range(15)]
					: VAL_W'($urandom);
				send_beat(op, pos, key, VAL_W'($urandom), VAL_W'($urandom));
				idle_gap(pct);
			end
		end

		// --- drain and verdict ---
		start <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d commands, %0d results checked,", issued, checked);
		$display("%0d appends refused on a full table", refusals);
		if (mismatches == 0 && waiting == 0) begin
			$display("PASS ordered_point_table");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, waiting);
			$display("FAIL ordered_point_table");
		end
		$finish;
	end

endmodule
